/* rtl/core/idll_pkg.sv */
// ----------------------------------------------------------------------------
// idll_pkg
// Shared types and constants of the indexed doubly linked list.
// ----------------------------------------------------------------------------
`default_nettype none

package idll_pkg;

  localparam int unsigned Capacity  = 256;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned NodeW     = $clog2(Capacity);
  localparam int unsigned LinkW     = NodeW + 1;
  localparam int unsigned PosW      = $clog2(Capacity + 1);
  localparam int unsigned ReqW      = 3;
  localparam int unsigned StatW     = 2;
  localparam int unsigned InW       = ((PosW + DataWidth + 7) / 8) * 8;
  localparam int unsigned OutW      = ((DataWidth + PosW + 7) / 8) * 8;

  localparam logic [LinkW-1:0] NilNode = LinkW'(Capacity);

  typedef enum logic [ReqW-1:0] {
    ReqAppend   = 3'd0,
    ReqPrepend  = 3'd1,
    ReqDelFirst = 3'd2,
    ReqDelLast  = 3'd3,
    ReqGet      = 3'd4,
    ReqSet      = 3'd5,
    ReqInsert   = 3'd6,
    ReqDelAt    = 3'd7
  } req_e;

  typedef enum logic [StatW-1:0] {
    StOk       = 2'd0,
    StBadIndex = 2'd1,
    StFull     = 2'd2,
    StEmpty    = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    SIdle,
    SDecode,
    SRead,
    SWalkStep,
    SNode,
    SUnlinkP,
    SUnlinkN,
    SAlloc,
    SAllocWait,
    SLinkX,
    SLinkP,
    SLinkN,
    SOut
  } state_e;

  typedef struct packed {
    logic [LinkW-1:0]     next_link;
    logic [LinkW-1:0]     prev_link;
    logic [DataWidth-1:0] value;
  } node_t;

endpackage

`default_nettype wire

/* rtl/core/indexed_doubly_linked_list.sv */
// ----------------------------------------------------------------------------
// indexed_doubly_linked_list
// Ordered list of words kept in a node memory with prev/next links.
// ----------------------------------------------------------------------------
// Requests are taken one item at a time, and the next item is accepted in the
// cycle after the result is taken. Values and links live in one node memory
// and freed nodes on a free stack, both read through a registered port. A
// failed request goes from decode straight to the result. Removal at either
// end reads the end node, unlinks it from its neighbours and frees it; append
// and prepend allocate a node, write it and link it to its neighbours. Indexed
// requests walk the links from the nearer end with one node read per cycle,
// over min(position, length - 1 - position) links, at most 127. Get and
// set then read or write the node, delete at unlinks it, insert links a new
// node before it. The list is empty after reset and needs no clearing pass.
`default_nettype none

module indexed_doubly_linked_list (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output      logic                               s_axis_tready,
  // position [8:0], data_word [40:9]
  input  wire logic [idll_pkg::InW-1:0]           s_axis_tdata,
  // req_type [2:0]
  input  wire logic [idll_pkg::ReqW-1:0]          s_axis_tuser,
  output      logic                               m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // read_value [31:0], list_length [40:32]
  output      logic [idll_pkg::OutW-1:0]          m_axis_tdata,
  // status [1:0]
  output      logic [idll_pkg::StatW-1:0]         m_axis_tuser
);

  localparam int unsigned NW = idll_pkg::NodeW;
  localparam int unsigned LW = idll_pkg::LinkW;
  localparam int unsigned DW = idll_pkg::DataWidth;
  localparam int unsigned PW = idll_pkg::PosW;

  idll_pkg::node_t node_mem [idll_pkg::Capacity];
  logic [NW-1:0]   free_mem [idll_pkg::Capacity];

  idll_pkg::state_e  state_q, state_d;
  idll_pkg::req_e    req_q;
  idll_pkg::status_e stat_q, dec_stat;
  logic [PW-1:0]     pos_q;
  logic [DW-1:0]     data_q, rd_q;
  logic [LW-1:0]     head_q, tail_q, x_q, p_q, n_q;
  logic [PW-1:0]     count_q, steps_q, free_cnt_q, bump_q;
  logic              fwd_q;
  idll_pkg::node_t   node_rd_q;
  logic [NW-1:0]     free_rd_q;

  logic [PW-1:0]   last_idx, start_steps;
  logic            walk_fwd, full, to_link;
  logic [LW-1:0]   walk_link, start_node;
  logic [NW-1:0]   node_ra, node_wa, free_ra;
  idll_pkg::node_t node_wd;
  logic            we_value, we_prev, we_next, free_we;

  assign full      = count_q >= PW'(idll_pkg::Capacity);
  assign last_idx  = count_q - PW'(1);
  assign walk_fwd  = pos_q <= (last_idx >> 1);
  assign walk_link = fwd_q ? node_rd_q.next_link : node_rd_q.prev_link;
  assign to_link   = (req_q == idll_pkg::ReqAppend) || (req_q == idll_pkg::ReqPrepend)
                  || ((req_q == idll_pkg::ReqInsert) && (pos_q == count_q));
  assign free_ra   = free_cnt_q[NW-1:0] - NW'(1);
  assign free_we   = (state_q == idll_pkg::SUnlinkN)
                  && (free_cnt_q < PW'(idll_pkg::Capacity));

  always_comb begin
    dec_stat = idll_pkg::StOk;
    unique case (req_q)
      idll_pkg::ReqAppend, idll_pkg::ReqPrepend: begin
        if (full) dec_stat = idll_pkg::StFull;
      end
      idll_pkg::ReqDelFirst, idll_pkg::ReqDelLast: begin
        if (count_q == '0) dec_stat = idll_pkg::StEmpty;
      end
      idll_pkg::ReqInsert: begin
        if (pos_q > count_q) dec_stat = idll_pkg::StBadIndex;
        else if (full) dec_stat = idll_pkg::StFull;
      end
      idll_pkg::ReqGet, idll_pkg::ReqSet, idll_pkg::ReqDelAt: begin
        if (pos_q >= count_q) dec_stat = idll_pkg::StBadIndex;
      end
    endcase
  end

  always_comb begin
    unique case (req_q)
      idll_pkg::ReqDelFirst: begin
        start_node  = head_q;
        start_steps = '0;
      end
      idll_pkg::ReqDelLast: begin
        start_node  = tail_q;
        start_steps = '0;
      end
      default: begin
        start_node  = walk_fwd ? head_q : tail_q;
        start_steps = walk_fwd ? pos_q : (last_idx - pos_q);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we_value) node_mem[node_wa].value     <= node_wd.value;
    if (we_prev)  node_mem[node_wa].prev_link <= node_wd.prev_link;
    if (we_next)  node_mem[node_wa].next_link <= node_wd.next_link;
    node_rd_q <= node_mem[node_ra];
  end

  always_ff @(posedge clk_i) begin
    if (free_we) free_mem[free_cnt_q[NW-1:0]] <= x_q[NW-1:0];
    free_rd_q <= free_mem[free_ra];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      idll_pkg::SIdle:      if (s_axis_tvalid) state_d = idll_pkg::SDecode;
      idll_pkg::SDecode: begin
        if (dec_stat != idll_pkg::StOk) state_d = idll_pkg::SOut;
        else if (to_link) state_d = idll_pkg::SAlloc;
        else state_d = idll_pkg::SRead;
      end
      idll_pkg::SRead: begin
        state_d = (steps_q == '0) ? idll_pkg::SNode : idll_pkg::SWalkStep;
      end
      idll_pkg::SWalkStep:  if (steps_q == PW'(1)) state_d = idll_pkg::SNode;
      idll_pkg::SNode: begin
        unique case (req_q)
          idll_pkg::ReqGet, idll_pkg::ReqSet: state_d = idll_pkg::SOut;
          idll_pkg::ReqInsert:                state_d = idll_pkg::SAlloc;
          default:                            state_d = idll_pkg::SUnlinkP;
        endcase
      end
      idll_pkg::SUnlinkP:   state_d = idll_pkg::SUnlinkN;
      idll_pkg::SUnlinkN:   state_d = idll_pkg::SOut;
      idll_pkg::SAlloc:     state_d = idll_pkg::SAllocWait;
      idll_pkg::SAllocWait: state_d = idll_pkg::SLinkX;
      idll_pkg::SLinkX:     state_d = idll_pkg::SLinkP;
      idll_pkg::SLinkP:     state_d = idll_pkg::SLinkN;
      idll_pkg::SLinkN:     state_d = idll_pkg::SOut;
      idll_pkg::SOut:       if (m_axis_tready) state_d = idll_pkg::SIdle;
      default:              state_d = idll_pkg::SIdle;
    endcase
  end

  always_comb begin
    s_axis_tready     = (state_q == idll_pkg::SIdle);
    m_axis_tvalid     = (state_q == idll_pkg::SOut);
    node_ra           = x_q[NW-1:0];
    node_wa           = x_q[NW-1:0];
    node_wd.value     = data_q;
    node_wd.prev_link = p_q;
    node_wd.next_link = n_q;
    we_value          = 1'b0;
    we_prev           = 1'b0;
    we_next           = 1'b0;
    unique case (state_q)
      idll_pkg::SWalkStep: node_ra = walk_link[NW-1:0];
      idll_pkg::SNode:     we_value = (req_q == idll_pkg::ReqSet);
      idll_pkg::SUnlinkP: begin
        node_wa = p_q[NW-1:0];
        we_next = (p_q != idll_pkg::NilNode);
      end
      idll_pkg::SUnlinkN: begin
        node_wa = n_q[NW-1:0];
        we_prev = (n_q != idll_pkg::NilNode);
      end
      idll_pkg::SLinkX: begin
        we_value = 1'b1;
        we_prev  = 1'b1;
        we_next  = 1'b1;
      end
      idll_pkg::SLinkP: begin
        node_wa           = p_q[NW-1:0];
        node_wd.next_link = x_q;
        we_next           = (p_q != idll_pkg::NilNode);
      end
      idll_pkg::SLinkN: begin
        node_wa           = n_q[NW-1:0];
        node_wd.prev_link = x_q;
        we_prev           = (n_q != idll_pkg::NilNode);
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tuser = stat_q;
  assign m_axis_tdata = idll_pkg::OutW'({count_q, rd_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= idll_pkg::SIdle;
      req_q      <= idll_pkg::ReqAppend;
      stat_q     <= idll_pkg::StOk;
      pos_q      <= '0;
      data_q     <= '0;
      rd_q       <= '0;
      head_q     <= idll_pkg::NilNode;
      tail_q     <= idll_pkg::NilNode;
      x_q        <= idll_pkg::NilNode;
      p_q        <= idll_pkg::NilNode;
      n_q        <= idll_pkg::NilNode;
      count_q    <= '0;
      steps_q    <= '0;
      free_cnt_q <= '0;
      bump_q     <= '0;
      fwd_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        idll_pkg::SIdle: begin
          if (s_axis_tvalid) begin
            req_q  <= idll_pkg::req_e'(s_axis_tuser);
            pos_q  <= s_axis_tdata[PW-1:0];
            data_q <= s_axis_tdata[PW+DW-1:PW];
            stat_q <= idll_pkg::StOk;
            rd_q   <= '0;
          end
        end
        idll_pkg::SDecode: begin
          stat_q  <= dec_stat;
          p_q     <= (req_q == idll_pkg::ReqPrepend) ? idll_pkg::NilNode : tail_q;
          n_q     <= (req_q == idll_pkg::ReqPrepend) ? head_q : idll_pkg::NilNode;
          x_q     <= start_node;
          steps_q <= start_steps;
          fwd_q   <= walk_fwd;
        end
        idll_pkg::SWalkStep: begin
          x_q     <= walk_link;
          steps_q <= steps_q - PW'(1);
        end
        idll_pkg::SNode: begin
          if (req_q == idll_pkg::ReqGet) rd_q <= node_rd_q.value;
          p_q <= node_rd_q.prev_link;
          n_q <= (req_q == idll_pkg::ReqInsert) ? x_q : node_rd_q.next_link;
        end
        idll_pkg::SUnlinkP: begin
          if (p_q == idll_pkg::NilNode) head_q <= n_q;
        end
        idll_pkg::SUnlinkN: begin
          if (n_q == idll_pkg::NilNode) tail_q <= p_q;
          if (free_we) free_cnt_q <= free_cnt_q + PW'(1);
          count_q <= count_q - PW'(1);
        end
        idll_pkg::SAllocWait: begin
          if (free_cnt_q != '0) begin
            x_q        <= {1'b0, free_rd_q};
            free_cnt_q <= free_cnt_q - PW'(1);
          end else begin
            x_q    <= {1'b0, bump_q[NW-1:0]};
            bump_q <= bump_q + PW'(1);
          end
        end
        idll_pkg::SLinkP: begin
          if (p_q == idll_pkg::NilNode) head_q <= x_q;
        end
        idll_pkg::SLinkN: begin
          if (n_q == idll_pkg::NilNode) tail_q <= x_q;
          count_q <= count_q + PW'(1);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* tb/sv/indexed_doubly_linked_list_tb.sv */
// ----------------------------------------------------------------------------
// indexed_doubly_linked_list_tb
// Self-checking testbench of the indexed doubly linked list.
// ----------------------------------------------------------------------------
// The scoreboard keeps the list as a plain queue of words. It works out the
// status, the word read and the new length of every accepted request, and it
// compares each returned item with the oldest expected one. Directed requests
// cover the empty list, full list and index edge cases. Random requests then
// follow on the long list, with random stalls on both streams for all but the last forty.
`default_nettype none

module indexed_doubly_linked_list_tb;

  localparam int unsigned MaxCycles = 1000000;
  localparam int unsigned DW = idll_pkg::DataWidth;
  localparam int unsigned PW = idll_pkg::PosW;

  typedef struct packed {
    idll_pkg::status_e status;
    logic [DW-1:0]     rd;
    logic [PW-1:0]     len;
  } list_result_t;

  class list_scoreboard;
    logic [DW-1:0] entries[$];
    list_result_t  pending[$];
    int unsigned   errors;
    int unsigned   checked;
    int unsigned   status_seen[4];

    function void note_request(idll_pkg::req_e req, logic [PW-1:0] pos, logic [DW-1:0] word);
      list_result_t r;
      int unsigned len;
      len = entries.size();
      r.status = idll_pkg::StOk;
      r.rd = '0;
      case (req)
        idll_pkg::ReqAppend, idll_pkg::ReqPrepend: begin
          if (len >= idll_pkg::Capacity) r.status = idll_pkg::StFull;
          else if (req == idll_pkg::ReqAppend) entries.push_back(word);
          else entries.push_front(word);
        end
        idll_pkg::ReqDelFirst, idll_pkg::ReqDelLast: begin
          if (len == 0) r.status = idll_pkg::StEmpty;
          else if (req == idll_pkg::ReqDelFirst) void'(entries.pop_front());
          else void'(entries.pop_back());
        end
        idll_pkg::ReqGet: begin
          if (pos >= len) r.status = idll_pkg::StBadIndex;
          else r.rd = entries[pos];
        end
        idll_pkg::ReqSet: begin
          if (pos >= len) r.status = idll_pkg::StBadIndex;
          else entries[pos] = word;
        end
        idll_pkg::ReqInsert: begin
          if (pos > len) r.status = idll_pkg::StBadIndex;
          else if (len >= idll_pkg::Capacity) r.status = idll_pkg::StFull;
          else entries.insert(pos, word);
        end
        default: begin
          if (pos >= len) r.status = idll_pkg::StBadIndex;
          else entries.delete(pos);
        end
      endcase
      r.len = PW'(entries.size());
      pending.push_back(r);
    endfunction

    function void check_result(logic [1:0] status, logic [DW-1:0] rd, logic [PW-1:0] len);
      list_result_t e;
      checked++;
      status_seen[status]++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected item status %0d value %h length %0d",
                 $time, status, rd, len);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (status !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, status);
        errors++;
      end
      if (rd !== e.rd) begin
        $display("%0t: read value expected %h actual %h", $time, e.rd, rd);
        errors++;
      end
      if (len !== e.len) begin
        $display("%0t: length expected %0d actual %0d", $time, e.len, len);
        errors++;
      end
    endfunction
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [idll_pkg::InW-1:0]      s_axis_tdata = '0;
  logic [idll_pkg::ReqW-1:0]     s_axis_tuser = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [idll_pkg::OutW-1:0]     m_axis_tdata;
  logic [idll_pkg::StatW-1:0]    m_axis_tuser;

  list_scoreboard sb = new();
  bit          stalls_on = 1'b1;
  bit          long_hold = 1'b0;
  int unsigned cycles = 0;

  indexed_doubly_linked_list DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MaxCycles) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tuser, m_axis_tdata[DW-1:0], m_axis_tdata[DW +: PW]);
  end

  initial begin
    forever begin
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        long_hold = 1'b0;
      end else if (stalls_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  task automatic send_request(idll_pkg::req_e req, logic [PW-1:0] pos, logic [DW-1:0] word);
    logic ready;
    s_axis_tuser  <= req;
    s_axis_tdata  <= idll_pkg::InW'({word, pos});
    s_axis_tvalid <= 1'b1;
    do begin
      @(negedge clk_i);
      ready = s_axis_tready;
      @(posedge clk_i);
    end while (!ready);
    sb.note_request(req, pos, word);
    if (stalls_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random();
    int unsigned len;
    int unsigned pick;
    idll_pkg::req_e req;
    logic [PW-1:0] pos;
    len = sb.entries.size();
    pick = $urandom_range(0, 9);
    if (len < 8 && pick < 4) begin
      req = ($urandom_range(0, 1) != 0) ? idll_pkg::ReqAppend : idll_pkg::ReqPrepend;
    end else begin
      req = idll_pkg::req_e'($urandom_range(0, 7));
    end
    if ($urandom_range(0, 9) < 8) pos = PW'($urandom_range(0, len));
    else pos = PW'($urandom_range(0, 511));
    send_request(req, pos, $urandom());
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty list: removals and indexed requests, then a short list built and probed.
    send_request(idll_pkg::ReqDelFirst, 9'd0, 32'd0);
    send_request(idll_pkg::ReqDelLast, 9'd0, 32'd0);
    send_request(idll_pkg::ReqGet, 9'd0, 32'd0);
    send_request(idll_pkg::ReqSet, 9'd0, 32'h1234_5678);
    send_request(idll_pkg::ReqDelAt, 9'd0, 32'd0);
    send_request(idll_pkg::ReqInsert, 9'd1, 32'd5);
    send_request(idll_pkg::ReqInsert, 9'd0, 32'h8000_0000);
    send_request(idll_pkg::ReqPrepend, 9'd0, 32'h7FFF_FFFF);
    send_request(idll_pkg::ReqAppend, 9'd0, 32'hFFFF_FFFF);
    send_request(idll_pkg::ReqInsert, 9'd3, 32'd0);
    send_request(idll_pkg::ReqInsert, 9'd2, 32'h5555_5555);
    send_request(idll_pkg::ReqGet, 9'd0, 32'd0);
    send_request(idll_pkg::ReqGet, 9'd3, 32'd0);
    send_request(idll_pkg::ReqGet, 9'd4, 32'd0);
    send_request(idll_pkg::ReqSet, 9'd2, 32'hAAAA_AAAA);
    send_request(idll_pkg::ReqGet, 9'd2, 32'd0);
    send_request(idll_pkg::ReqDelAt, 9'd1, 32'd0);
    send_request(idll_pkg::ReqGet, 9'd511, 32'd0);
    send_request(idll_pkg::ReqDelAt, 9'd256, 32'd0);
    send_request(idll_pkg::ReqDelFirst, 9'd0, 32'd0);
    send_request(idll_pkg::ReqDelLast, 9'd0, 32'd0);
    send_request(idll_pkg::ReqDelAt, 9'd0, 32'd0);

    // Output held off while requests keep coming, so the input stalls.
    long_hold = 1'b1;
    for (int i = 0; i < 20; i++) send_request(idll_pkg::ReqAppend, 9'd0, $urandom());
    wait_drained();

    // Fill to capacity and probe the full list.
    while (sb.entries.size() < idll_pkg::Capacity)
      send_request(idll_pkg::ReqAppend, 9'd0, $urandom());
    send_request(idll_pkg::ReqAppend, 9'd0, 32'd1);
    send_request(idll_pkg::ReqPrepend, 9'd0, 32'd2);
    send_request(idll_pkg::ReqInsert, 9'd100, 32'd3);
    send_request(idll_pkg::ReqInsert, 9'd256, 32'd4);
    send_request(idll_pkg::ReqInsert, 9'd257, 32'd5);
    send_request(idll_pkg::ReqGet, 9'd255, 32'd0);
    send_request(idll_pkg::ReqGet, 9'd127, 32'd0);
    send_request(idll_pkg::ReqGet, 9'd128, 32'd0);
    send_request(idll_pkg::ReqSet, 9'd256, 32'd0);
    send_request(idll_pkg::ReqDelAt, 9'd128, 32'd0);
    send_request(idll_pkg::ReqInsert, 9'd128, 32'h0F0F_0F0F);
    send_request(idll_pkg::ReqGet, 9'd128, 32'd0);
    wait_drained();

    for (int i = 0; i < 170; i++) begin
      if (i == 130) stalls_on = 1'b0;
      send_random();
    end
    s_axis_tvalid <= 1'b0;

    wait_drained();
    repeat (300) @(posedge clk_i);
    $display("checked %0d results: ok %0d, bad index %0d, full %0d, empty %0d",
             sb.checked, sb.status_seen[idll_pkg::StOk], sb.status_seen[idll_pkg::StBadIndex],
             sb.status_seen[idll_pkg::StFull], sb.status_seen[idll_pkg::StEmpty]);
    $display("empty and full lists probed, long list exercised at random; %0d errors",
             sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      if (sb.pending.size() != 0)
        $display("%0t: %0d expected items never arrived", $time, sb.pending.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
